// ===== src/mtrf_pkg.sv =====
// ----------------------------------------------------------------------------
// mtrf_pkg
// Shared types and constants of the Modbus TCP read request framer.
// ----------------------------------------------------------------------------
package mtrf_pkg;

  // Input item kinds.
  localparam logic KindRequest  = 1'b0;
  localparam logic KindResponse = 1'b1;

  // Function select code that has no Modbus function behind it.
  localparam logic [1:0] SelUnused = 2'd3;
  localparam logic [1:0] SelDiscrete = 2'd0;
  localparam logic [7:0] FuncBase = 8'd2;

  // Result item kinds.
  localparam logic [1:0] OutFrameByte = 2'd0;
  localparam logic [1:0] OutDataByte  = 2'd1;
  localparam logic [1:0] OutStatus    = 2'd2;

  // Request frame layout.
  localparam logic [7:0] MbapLength   = 8'h06;
  localparam logic [7:0] ProtocolByte = 8'h00;
  localparam int unsigned FrameBytes  = 12;
  localparam int unsigned StepWidth   = $clog2(FrameBytes);

  // Response header offsets.
  localparam int unsigned PosWidth = 18;
  localparam logic [PosWidth-1:0] PosMax   = {PosWidth{1'b1}};
  localparam logic [PosWidth-1:0] PosIdHi  = 18'd0;
  localparam logic [PosWidth-1:0] PosIdLo  = 18'd1;
  localparam logic [PosWidth-1:0] PosUnit  = 18'd6;
  localparam logic [PosWidth-1:0] PosFunc  = 18'd7;
  localparam logic [PosWidth-1:0] PosCount = 18'd8;
  localparam logic [PosWidth-1:0] PosData  = 18'd9;
  localparam logic [PosWidth-1:0] HeaderLength = 18'd9;

  localparam int unsigned FIFO_DEPTH = 4;

  typedef enum logic {
    CmdRequest  = 1'b0,
    CmdResponse = 1'b1
  } mtrf_cmd_e;

  // One command from the front part to the back part.
  typedef struct packed {
    mtrf_cmd_e   kind;
    logic [15:0] tid;
    logic [7:0]  unit;
    logic [7:0]  func;
    logic [15:0] addr;
    logic [15:0] qty;
    logic        has_data;
    logic [7:0]  data;
    logic        has_status;
    logic        frame_complete;
    logic        id_match;
    logic        function_match;
    logic [7:0]  unit_seen;
    logic [7:0]  byte_count_seen;
  } mtrf_cmd_t;

endpackage

// ===== src/mtrf_front.sv =====
// ----------------------------------------------------------------------------
// mtrf_front
// Accepts input items, keeps the transaction and response tracking state and
// turns each item into at most one command for the back part.
// ----------------------------------------------------------------------------
module mtrf_front import mtrf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic        kind_i,
  input  logic [1:0]  function_select_i,
  input  logic [7:0]  unit_address_i,
  input  logic [15:0] start_address_i,
  input  logic [15:0] quantity_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        rx_last_i,
  output logic        push_o,
  output mtrf_cmd_t   cmd_o
);

  logic [15:0]         last_id_q, last_id_d;
  logic [15:0]         request_id_q, request_id_d;
  logic [7:0]          request_function_q, request_function_d;
  logic [PosWidth-1:0] expected_length_q, expected_length_d;
  logic [PosWidth-1:0] rx_position_q, rx_position_d;
  logic [15:0]         rx_id_q, rx_id_d;
  logic [7:0]          rx_function_q, rx_function_d;
  logic [7:0]          rx_unit_q, rx_unit_d;
  logic [7:0]          rx_count_q, rx_count_d;

  logic                is_request;
  logic                sel_ok;
  logic [15:0]         next_id;
  logic [7:0]          func_code;
  logic [PosWidth-1:0] exp_len;
  logic [PosWidth-1:0] pos_inc;
  logic [15:0]         cap_id;
  logic [7:0]          cap_unit, cap_func, cap_count;
  logic                has_data;

  always_comb begin
    is_request = (kind_i == KindRequest);
    sel_ok     = (function_select_i != SelUnused);
    next_id    = (last_id_q == 16'hFFFF) ? 16'd1 : last_id_q + 16'd1;
    func_code  = {6'd0, function_select_i} + FuncBase;
    if (function_select_i == SelDiscrete) begin
      exp_len = HeaderLength + ((PosWidth'(quantity_i) + PosWidth'(7)) >> 3);
    end else begin
      exp_len = HeaderLength + {1'b0, quantity_i, 1'b0};
    end

    cap_id    = rx_id_q;
    cap_unit  = rx_unit_q;
    cap_func  = rx_function_q;
    cap_count = rx_count_q;
    case (rx_position_q)
      PosIdHi:  cap_id[15:8] = rx_byte_i;
      PosIdLo:  cap_id[7:0]  = rx_byte_i;
      PosUnit:  cap_unit     = rx_byte_i;
      PosFunc:  cap_func     = rx_byte_i;
      PosCount: cap_count    = rx_byte_i;
      default: ;
    endcase
    pos_inc  = (rx_position_q == PosMax) ? rx_position_q : rx_position_q + 1'b1;
    has_data = (rx_position_q >= PosData);

    last_id_d          = last_id_q;
    request_id_d       = request_id_q;
    request_function_d = request_function_q;
    expected_length_d  = expected_length_q;
    rx_position_d      = rx_position_q;
    rx_id_d            = rx_id_q;
    rx_function_d      = rx_function_q;
    rx_unit_d          = rx_unit_q;
    rx_count_d         = rx_count_q;

    cmd_o                 = '0;
    cmd_o.tid             = request_id_q;
    cmd_o.unit            = unit_address_i;
    cmd_o.addr            = start_address_i;
    cmd_o.qty             = quantity_i;
    cmd_o.func            = func_code;
    cmd_o.data            = rx_byte_i;
    cmd_o.frame_complete  = (pos_inc == expected_length_q);
    cmd_o.id_match        = (cap_id == request_id_q);
    cmd_o.function_match  = (cap_func == request_function_q);
    cmd_o.unit_seen       = cap_unit;
    cmd_o.byte_count_seen = cap_count;
    push_o                = 1'b0;

    if (is_request) begin
      cmd_o.kind = CmdRequest;
      cmd_o.tid  = next_id;
      if (accept_i && sel_ok) begin
        push_o             = 1'b1;
        last_id_d          = next_id;
        request_id_d       = next_id;
        request_function_d = func_code;
        expected_length_d  = exp_len;
        rx_position_d      = '0;
        rx_id_d            = '0;
        rx_function_d      = '0;
        rx_unit_d          = '0;
        rx_count_d         = '0;
      end
    end else begin
      cmd_o.kind       = CmdResponse;
      cmd_o.has_data   = has_data;
      cmd_o.has_status = rx_last_i;
      if (accept_i) begin
        push_o = has_data || rx_last_i;
        // The byte marked last closes the response, so tracking starts over.
        if (rx_last_i) begin
          rx_position_d = '0;
          rx_id_d       = '0;
          rx_function_d = '0;
          rx_unit_d     = '0;
          rx_count_d    = '0;
        end else begin
          rx_position_d = pos_inc;
          rx_id_d       = cap_id;
          rx_function_d = cap_func;
          rx_unit_d     = cap_unit;
          rx_count_d    = cap_count;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_id_q          <= '0;
      request_id_q       <= '0;
      request_function_q <= '0;
      expected_length_q  <= '0;
      rx_position_q      <= '0;
      rx_id_q            <= '0;
      rx_function_q      <= '0;
      rx_unit_q          <= '0;
      rx_count_q         <= '0;
    end else begin
      last_id_q          <= last_id_d;
      request_id_q       <= request_id_d;
      request_function_q <= request_function_d;
      expected_length_q  <= expected_length_d;
      rx_position_q      <= rx_position_d;
      rx_id_q            <= rx_id_d;
      rx_function_q      <= rx_function_d;
      rx_unit_q          <= rx_unit_d;
      rx_count_q         <= rx_count_d;
    end
  end

  // Once a request has gone out, the id it took is never zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && is_request && sel_ok) |=> (request_id_q != 16'd0))
    else $error("issued transaction id is zero");

endmodule

// ===== src/mtrf_fifo.sv =====
// ----------------------------------------------------------------------------
// mtrf_fifo
// Short command queue between the front and the back part.
// ----------------------------------------------------------------------------
module mtrf_fifo import mtrf_pkg::*; #(
  parameter int unsigned Depth = FIFO_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  mtrf_cmd_t wdata_i,
  input  logic      pop_i,
  output mtrf_cmd_t rdata_o,
  output logic      empty_o,
  output logic      full_o
);

  localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntWidth = $clog2(Depth + 1);
  localparam logic [PtrWidth-1:0] PtrLast = PtrWidth'(Depth - 1);
  localparam logic [CntWidth-1:0] CntFull = CntWidth'(Depth);

  mtrf_cmd_t            mem_q [Depth];
  logic [PtrWidth-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0]  count_q, count_d;
  logic                 do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntFull);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntFull)
    else $error("queue fill count beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with pointers apart");

endmodule

// ===== src/mtrf_back.sv =====
// ----------------------------------------------------------------------------
// mtrf_back
// Expands queued commands into result items, one per cycle while not stalled.
// ----------------------------------------------------------------------------
module mtrf_back import mtrf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  mtrf_cmd_t   cmd_i,
  input  logic        empty_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  out_kind_o,
  output logic [7:0]  out_byte_o,
  output logic        out_last_o,
  output logic [15:0] transaction_id_o,
  output logic        frame_complete_o,
  output logic        id_match_o,
  output logic        function_match_o,
  output logic [7:0]  unit_seen_o,
  output logic [7:0]  byte_count_seen_o
);

  localparam logic [StepWidth-1:0] StepLast = StepWidth'(FrameBytes - 1);

  mtrf_cmd_t            cur_q;
  logic                 cur_valid_q, cur_valid_d;
  logic [StepWidth-1:0] step_q, step_d;
  logic                 is_status;
  logic                 is_last_sub;
  logic                 advance;
  logic                 load;

  always_comb begin
    is_status = (cur_q.kind == CmdResponse) && !(cur_q.has_data && step_q == '0);
    if (cur_q.kind == CmdRequest) begin
      is_last_sub = (step_q == StepLast);
    end else begin
      is_last_sub = is_status || !cur_q.has_status;
    end
    advance = cur_valid_q && !out_stall_i;
    load    = (!cur_valid_q || (advance && is_last_sub)) && !empty_i;
    pop_o   = load;

    cur_valid_d = cur_valid_q;
    step_d      = step_q;
    if (load) begin
      cur_valid_d = 1'b1;
      step_d      = '0;
    end else if (advance) begin
      if (is_last_sub) begin
        cur_valid_d = 1'b0;
      end else begin
        step_d = step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      cur_valid_q <= cur_valid_d;
      step_q      <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= cmd_i;
    end
  end

  always_comb begin
    out_valid_o       = cur_valid_q;
    transaction_id_o  = cur_q.tid;
    out_byte_o        = '0;
    out_last_o        = 1'b0;
    frame_complete_o  = 1'b0;
    id_match_o        = 1'b0;
    function_match_o  = 1'b0;
    unit_seen_o       = '0;
    byte_count_seen_o = '0;
    if (cur_q.kind == CmdRequest) begin
      out_kind_o = OutFrameByte;
      out_last_o = (step_q == StepLast);
      case (step_q)
        4'd0:    out_byte_o = cur_q.tid[15:8];
        4'd1:    out_byte_o = cur_q.tid[7:0];
        4'd2:    out_byte_o = ProtocolByte;
        4'd3:    out_byte_o = ProtocolByte;
        4'd4:    out_byte_o = 8'h00;
        4'd5:    out_byte_o = MbapLength;
        4'd6:    out_byte_o = cur_q.unit;
        4'd7:    out_byte_o = cur_q.func;
        4'd8:    out_byte_o = cur_q.addr[15:8];
        4'd9:    out_byte_o = cur_q.addr[7:0];
        4'd10:   out_byte_o = cur_q.qty[15:8];
        4'd11:   out_byte_o = cur_q.qty[7:0];
        default: out_byte_o = '0;
      endcase
    end else if (is_status) begin
      out_kind_o        = OutStatus;
      out_last_o        = 1'b1;
      frame_complete_o  = cur_q.frame_complete;
      id_match_o        = cur_q.id_match;
      function_match_o  = cur_q.function_match;
      unit_seen_o       = cur_q.unit_seen;
      byte_count_seen_o = cur_q.byte_count_seen;
    end else begin
      out_kind_o = OutDataByte;
      out_byte_o = cur_q.data;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_valid_q && cur_q.kind == CmdRequest) |-> (step_q <= StepLast))
    else $error("frame step past the last frame byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_valid_q && out_stall_i) |=> (cur_valid_q && $stable(step_q)))
    else $error("result item moved while stalled");

endmodule

// ===== src/modbus_tcp_read_request_framer.sv =====
// ----------------------------------------------------------------------------
// modbus_tcp_read_request_framer
// Modbus TCP client framer for read requests and checker for their responses.
// ----------------------------------------------------------------------------
// A request item (function code 2, 3 or 4) takes the next transaction id,
// which runs from 1 to 65535 and wraps to 1, and gives the 12 result items of
// the request frame. A response byte item gives one data item from offset 9
// on and, on the byte marked last, one status item. Input items are taken one
// per cycle while the command queue of FifoDepth entries has room; the back
// part hands out one result item per cycle while out_stall_i is low. A request
// with function select 3 is taken and dropped.
module modbus_tcp_read_request_framer import mtrf_pkg::*; #(
  parameter int unsigned FifoDepth = FIFO_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [1:0]  function_select_i,
  input  logic [7:0]  unit_address_i,
  input  logic [15:0] start_address_i,
  input  logic [15:0] quantity_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        rx_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  out_kind_o,
  output logic [7:0]  out_byte_o,
  output logic        out_last_o,
  output logic [15:0] transaction_id_o,
  output logic        frame_complete_o,
  output logic        id_match_o,
  output logic        function_match_o,
  output logic [7:0]  unit_seen_o,
  output logic [7:0]  byte_count_seen_o
);

  mtrf_cmd_t push_cmd, head_cmd;
  logic      push, pop, empty, full, accept;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  mtrf_front u_front (
    .clk_i,
    .rst_ni,
    .accept_i          (accept),
    .kind_i,
    .function_select_i,
    .unit_address_i,
    .start_address_i,
    .quantity_i,
    .rx_byte_i,
    .rx_last_i,
    .push_o            (push),
    .cmd_o             (push_cmd)
  );

  mtrf_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .wdata_i (push_cmd),
    .pop_i   (pop),
    .rdata_o (head_cmd),
    .empty_o (empty),
    .full_o  (full)
  );

  mtrf_back u_back (
    .clk_i,
    .rst_ni,
    .cmd_i   (head_cmd),
    .empty_i (empty),
    .pop_o   (pop),
    .out_valid_o,
    .out_stall_i,
    .out_kind_o,
    .out_byte_o,
    .out_last_o,
    .transaction_id_o,
    .frame_complete_o,
    .id_match_o,
    .function_match_o,
    .unit_seen_o,
    .byte_count_seen_o
  );

endmodule
